@@ design/box_nonmax_suppression_macros.svh @@
// assertion macros for the box non-maximum suppression block
// no dependencies
`ifndef BOX_NONMAX_SUPPRESSION_MACROS_SVH
`define BOX_NONMAX_SUPPRESSION_MACROS_SVH
`ifndef SYNTHESIS
`define BNMS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BNMS_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BNMS_ASSERT(label, clk, rst, prop, msg)
`define BNMS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ design/bnms_pkg.sv @@
// shared types and constants for box non-maximum suppression
// no dependencies
package bnms_pkg;

   localparam logic [15:0] THRESH_RESET = 16'd29491;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic signed [15:0] box_left;
      logic signed [15:0] box_top;
      logic signed [15:0] box_width;
      logic signed [15:0] box_height;
      logic [15:0]        score;
      logic signed [7:0]  class_tag;
      logic               last_box;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] kept_left;
      logic signed [15:0] kept_top;
      logic signed [15:0] kept_width;
      logic signed [15:0] kept_height;
      logic [15:0]        kept_score;
      logic signed [7:0]  kept_class;
      logic               dropped_overflow;
      logic               last_kept;
   } rsp_word_type;

   // command from front to back
   typedef struct packed {
      logic [63:0] coords;
      logic [15:0] score;
      logic [7:0]  class_tag;
      logic        store;      // write into the store
      logic        last_box;   // run suppression afterwards
   } cmd_type;

endpackage

@@ design/bnms_front.sv @@
// front end: accepts input words, classifies store or drop, queues commands
// depends on bnms_pkg
module bnms_front #(
   parameter int MAX_BOXES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bnms_pkg::req_word_type req_word,
   output logic                  cmd_valid,
   input  logic                  cmd_pop,
   output bnms_pkg::cmd_type     cmd_word
);
   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam int QD = bnms_pkg::QUEUE_DEPTH;

   bnms_pkg::cmd_type q_ff [QD];
   logic         rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic [CW-1:0] acc_ff, acc_in;   // boxes accepted into the current list
   logic         push;
   bnms_pkg::cmd_type nc;

   assign req_stall = (cnt_ff == 2'(QD));
   assign push = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_word = q_ff[rd_ff];

   always_comb begin
      nc.coords = {req_word.box_height, req_word.box_width, req_word.box_top,
                   req_word.box_left};
      nc.score = req_word.score;
      nc.class_tag = req_word.class_tag;
      nc.store = (acc_ff < CW'(MAX_BOXES));
      nc.last_box = req_word.last_box;
      rd_in = rd_ff ^ (cmd_pop && cmd_valid);
      wr_in = wr_ff ^ push;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop && cmd_valid);
      acc_in = acc_ff;
      if (push) begin
         if (req_word.last_box) begin
            acc_in = '0;
         end else if (nc.store) begin
            acc_in = acc_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= nc;
      end
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= '0;
         acc_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
         acc_ff <= acc_in;
      end
   end
endmodule

@@ design/bnms_overlap.sv @@
// three-stage overlap test: intersection*65536 > threshold*union
// depends on nothing
module bnms_overlap (
   input  logic        clock,
   input  logic [63:0] box_a,
   input  logic [63:0] box_b,
   input  logic [15:0] thresh,
   output logic        hit    // registered
);
   logic signed [17:0] al, at, aw, ah, bl, bt, bw, bh, x0, x1, y0, y1;
   logic signed [17:0] dx_ff, dy_ff;
   logic [31:0] aa_ff, ba_ff;
   logic        ok_ff, ok2_ff;
   logic [15:0] th_ff;
   logic [31:0] inter, inter_ff;
   logic [33:0] uni, uni_ff;
   logic [49:0] scaled, bound;
   logic        hit_ff;

   always_comb begin
      al = 18'(signed'(box_a[15:0]));  at = 18'(signed'(box_a[31:16]));
      aw = 18'(signed'(box_a[47:32])); ah = 18'(signed'(box_a[63:48]));
      bl = 18'(signed'(box_b[15:0]));  bt = 18'(signed'(box_b[31:16]));
      bw = 18'(signed'(box_b[47:32])); bh = 18'(signed'(box_b[63:48]));
      x0 = (al > bl) ? al : bl;
      y0 = (at > bt) ? at : bt;
      x1 = ((al + aw) < (bl + bw)) ? (al + aw) : (bl + bw);
      y1 = ((at + ah) < (bt + bh)) ? (at + ah) : (bt + bh);
   end

   always_ff @(posedge clock) begin
      dx_ff <= x1 - x0;
      dy_ff <= y1 - y0;
      aa_ff <= 32'(aw[15:0]) * 32'(ah[15:0]);
      ba_ff <= 32'(bw[15:0]) * 32'(bh[15:0]);
      th_ff <= thresh;
      ok_ff <= (aw > 0) && (ah > 0) && (bw > 0) && (bh > 0) && (x1 > x0) && (y1 > y0);
   end

   // widths/heights positive under ok, so the overlap sides fit in 15 bits
   always_comb begin
      inter = dx_ff[15:0] * dy_ff[15:0];
      uni = 34'(aa_ff) + 34'(ba_ff) - 34'(inter);
   end

   always_ff @(posedge clock) begin
      inter_ff <= inter;
      uni_ff <= uni;
      ok2_ff <= ok_ff;
   end

   always_comb begin
      scaled = {2'b00, inter_ff, 16'd0};
      bound = th_ff * uni_ff;
   end

   always_ff @(posedge clock) begin
      hit_ff <= ok2_ff && (uni_ff != '0) && (scaled > bound);
   end
   assign hit = hit_ff;
endmodule

@@ design/bnms_back.sv @@
// back end: box store, stable insertion sort, greedy suppression, output
// depends on bnms_pkg, bnms_overlap
module bnms_back #(
   parameter int MAX_BOXES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           thresh,
   input  logic                  cmd_valid,
   output logic                  cmd_pop,
   input  bnms_pkg::cmd_type     cmd_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bnms_pkg::rsp_word_type rsp_word,
   output logic                  busy
);
   localparam int AW = $clog2(MAX_BOXES);
   localparam int CW = $clog2(MAX_BOXES + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_NEXTI = 8'b00000010,
      S_SRD   = 8'b00000100,  // read score of order[j-1]
      S_SCMP  = 8'b00001000,  // compare, shift
      S_PLACE = 8'b00010000,  // box i goes to the front
      S_OI    = 8'b00100000,  // fetch outer box
      S_OJ    = 8'b01000000,  // sweep inner boxes
      S_EMIT  = 8'b10000000
   } state_type;

   state_type state_ff;
   logic [63:0] coord_mem [MAX_BOXES];
   logic [15:0] score_mem [MAX_BOXES];
   logic [7:0]  class_mem [MAX_BOXES];
   logic [AW-1:0] order_mem [MAX_BOXES];
   logic [MAX_BOXES-1:0] sup_ff;
   logic [CW-1:0] n_ff, i_ff, j_ff;
   logic ovf_ff;
   logic [15:0] key_ff;
   logic [AW-1:0] prev_ff;         // order[j-1]
   logic [15:0] psc_ff;
   logic [63:0] ca_ff, cb_ff;
   logic [15:0] sa_ff; logic [7:0] cla_ff;
   logic [AW-1:0] bi_ff;
   logic [AW-1:0] ob_ff;           // inner box index read from the order store
   logic [AW-1:0] pa_ff, p1_ff, p2_ff, p3_ff, p4_ff;  // inner positions along the pipe
   logic va_ff, v0_ff, v1_ff, v2_ff, v3_ff;
   logic hit;
   logic rv_ff;
   bnms_pkg::rsp_word_type rw_ff;
   logic more;
   logic emit_go;

   bnms_overlap u_ov (.clock(clock), .box_a(ca_ff), .box_b(cb_ff), .thresh(thresh),
                      .hit(hit));

   assign busy = (state_ff != S_IDLE) || rv_ff;
   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_word = rw_ff;
   assign emit_go = (state_ff == S_EMIT) && (!rv_ff || !rsp_stall);

   // any unsuppressed box beyond i (after the sweep finished)
   always_comb begin
      more = 1'b0;
      for (int k = 0; k < MAX_BOXES; k++) begin
         if (CW'(k) > i_ff && CW'(k) < n_ff && !sup_ff[k]) more = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sup_ff <= '0;
         n_ff <= '0;
         ovf_ff <= 1'b0;
         rv_ff <= 1'b0;
         i_ff <= '0;
         j_ff <= '0;
         va_ff <= 1'b0;
         v0_ff <= 1'b0; v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
      end else begin
         if (emit_go) begin
            rv_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rv_ff <= 1'b0;
         end
         v0_ff <= va_ff; v1_ff <= v0_ff; v2_ff <= v1_ff; v3_ff <= v2_ff;
         p1_ff <= pa_ff; p2_ff <= p1_ff; p3_ff <= p2_ff; p4_ff <= p3_ff;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_pop) begin
                  if (cmd_word.store) begin
                     coord_mem[n_ff[AW-1:0]] <= cmd_word.coords;
                     score_mem[n_ff[AW-1:0]] <= cmd_word.score;
                     class_mem[n_ff[AW-1:0]] <= cmd_word.class_tag;
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (cmd_word.store) n_ff <= n_ff + CW'(1);
                  if (cmd_word.last_box) begin
                     state_ff <= S_NEXTI;
                     i_ff <= '0;
                  end
               end
            end
            S_NEXTI: begin
               if (i_ff >= n_ff) begin
                  state_ff <= S_OI;
                  i_ff <= '0;
               end else begin
                  key_ff <= score_mem[i_ff[AW-1:0]];
                  j_ff <= i_ff;
                  if (i_ff == '0) begin
                     order_mem[0] <= '0;
                     i_ff <= i_ff + CW'(1);
                  end else begin
                     state_ff <= S_SRD;
                     prev_ff <= order_mem[i_ff[AW-1:0] - AW'(1)];
                  end
               end
            end
            S_SRD: begin
               psc_ff <= score_mem[prev_ff];
               state_ff <= S_SCMP;
            end
            S_SCMP: begin
               if (psc_ff < key_ff) begin
                  order_mem[j_ff[AW-1:0]] <= prev_ff;
                  j_ff <= j_ff - CW'(1);
                  if (j_ff == CW'(1)) begin
                     state_ff <= S_PLACE;
                  end else begin
                     prev_ff <= order_mem[j_ff[AW-1:0] - AW'(2)];
                     state_ff <= S_SRD;
                  end
               end else begin
                  order_mem[j_ff[AW-1:0]] <= i_ff[AW-1:0];
                  i_ff <= i_ff + CW'(1);
                  state_ff <= S_NEXTI;
               end
            end
            S_PLACE: begin
               order_mem[j_ff[AW-1:0]] <= i_ff[AW-1:0];
               i_ff <= i_ff + CW'(1);
               state_ff <= S_NEXTI;
            end
            S_OI: begin
               // i_ff is next candidate; skip suppressed
               if (i_ff >= n_ff) begin
                  sup_ff <= '0; n_ff <= '0; ovf_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end else if (sup_ff[i_ff[AW-1:0]]) begin
                  i_ff <= i_ff + CW'(1);
               end else begin
                  bi_ff <= order_mem[i_ff[AW-1:0]];
                  j_ff <= i_ff + CW'(1);
                  state_ff <= S_OJ;
                  va_ff <= 1'b0;
               end
            end
            S_OJ: begin
               ca_ff <= coord_mem[bi_ff];
               sa_ff <= score_mem[bi_ff];
               cla_ff <= class_mem[bi_ff];
               cb_ff <= coord_mem[ob_ff];
               if (j_ff < n_ff) begin
                  ob_ff <= order_mem[j_ff[AW-1:0]];
                  pa_ff <= j_ff[AW-1:0];
                  va_ff <= 1'b1;
                  j_ff <= j_ff + CW'(1);
               end else begin
                  va_ff <= 1'b0;
               end
               if (v3_ff && hit) sup_ff[p4_ff] <= 1'b1;
               // last test lands this cycle at the latest
               if (j_ff >= n_ff && !va_ff && !v0_ff && !v1_ff && !v2_ff) state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (emit_go) begin
                  rw_ff <= {ca_ff[15:0], ca_ff[31:16], ca_ff[47:32], ca_ff[63:48],
                            sa_ff, cla_ff, ovf_ff, !more};
                  i_ff <= i_ff + CW'(1);
                  state_ff <= S_OI;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ design/box_nonmax_suppression.sv @@
// box non-maximum suppression top: bnms_front word queue, bnms_back store, sort and sweep
// words load one a cycle while the back end is idle; after the last box of a list the
// insertion sort orders the boxes by descending score, then each kept box sweeps the later
// boxes at one overlap test a cycle. flow: one list at a time; input stalls once the
// two-word queue fills. reset: synchronous, active high; clears the list, threshold 29491
`include "box_nonmax_suppression_macros.svh"
module box_nonmax_suppression #(
   parameter int MAX_BOXES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bnms_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bnms_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write,
   input  logic [15:0]            csr_data
);
   // threshold register
   logic [15:0] thresh_ff;
   logic        cmd_valid, cmd_pop, busy;
   bnms_pkg::cmd_type cmd_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= bnms_pkg::THRESH_RESET;
      end else if (csr_write) begin
         thresh_ff <= csr_data;
      end
   end

   // front: queue of stored or dropped words
   bnms_front #(.MAX_BOXES(MAX_BOXES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .cmd_valid, .cmd_pop, .cmd_word);

   // back: store, sort, suppress, emit
   bnms_back #(.MAX_BOXES(MAX_BOXES)) u_back (
      .clock, .reset, .thresh(thresh_ff), .cmd_valid, .cmd_pop, .cmd_word,
      .rsp_valid, .rsp_stall, .rsp_word, .busy);

   `BNMS_ASSERT(a_pop_needs_valid, clock, reset, cmd_pop |-> cmd_valid, "pop from empty queue")
   `BNMS_ASSERT(a_rsp_busy, clock, reset, rsp_valid |-> busy, "result while idle")
endmodule
